// ===== rtl/pmid_pkg.sv =====
// ---------------------------------------------------------------------------
// pmid_pkg
// Shared widths, register indexes and the square-root chain record for the
// periodic minimum-image distance block.
// ---------------------------------------------------------------------------
package pmid_pkg;

  // Domain extent registers
  localparam int DIM_W = 16;
  localparam logic [DIM_W-1:0] DIM_RESET = 16'hFFFF;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_HEIGHT = 2'd1;

  // Per-axis magnitude, clamped: anything at or above 2^17 squares past the cap
  localparam int MAG_W = 18;
  localparam logic [MAG_W-1:0] MAG_SAT = 18'h20000;
  localparam int SQ_W = 2 * MAG_W;

  // Least squared distance never exceeds 4*w*h < 2^34
  localparam int BEST_W = 34;
  localparam int ROOT_W = BEST_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  // Result stream
  localparam int OUT_TDATA_W = ((ROOT_W + 7) / 8) * 8;

  // One item as it walks down the square-root chain
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BEST_W-1:0] rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

endpackage

// ===== rtl/periodic_min_image_distance.sv =====
// ---------------------------------------------------------------------------
// periodic_min_image_distance
// Minimum-image distance between two points in a 2-D periodic rectangle.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one item per point pair, ref and other coordinates in
//   in_tdata, end-of-list flag on in_tlast. Result stream (out_*): floor of the
//   square root of the least squared distance over the nine periodic images,
//   capped at 4*width*height, with the list flag on out_tlast. Config port
//   (cfg_*): index 0 = domain width, 1 = domain height, other indexes ignored;
//   always ready. Write only while no item is in flight; not enforced.
// Pipeline and throughput:
//   From input accept to out_tvalid the item passes four stages per axis
//   (offsets, magnitudes, minimum, square), one stage for the sum and cap
//   compare, a chain of 17 square-root cells, one root bit each, and the
//   output register. One item per cycle sustained while in_tready is high.
// Reset:
//   Clears all valid bits and loads both extents with 65535.
// Stall:
//   The output register has a one-item skid stage behind it. in_tready drops
//   only when the skid stage is occupied; the whole pipeline then holds.
// ---------------------------------------------------------------------------
module periodic_min_image_distance #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: ref_x, ref_y, other_x, other_y (from bit 0 up), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tvalid,
  input  logic                                  in_tlast,
  output logic                                  in_tready,
  // out_tdata: distance (from bit 0 up), zero padded
  output logic [pmid_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  output logic                                  out_tlast,
  input  logic                                  out_tready,
  // Configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmid_pkg::DIM_W-1:0]            cfg_data
);

  localparam int NSTG = 5;

  logic [pmid_pkg::DIM_W-1:0]    width_r, height_r;
  logic [2*pmid_pkg::DIM_W-1:0]  area_r;
  logic [pmid_pkg::BEST_W-1:0]   cap;
  logic                          en;
  logic [NSTG-1:0]               vld_r, last_r;
  logic [pmid_pkg::SQ_W-1:0]     sqx, sqy;
  logic [pmid_pkg::SQ_W:0]       sum;
  logic [pmid_pkg::BEST_W-1:0]   best_r;
  pmid_pkg::sqrt_stage_t         chain_head;
  pmid_pkg::sqrt_stage_t         chain [pmid_pkg::ROOT_W+1];
  logic                          pop, push;
  logic [pmid_pkg::ROOT_W-1:0]   dist_r, sk_dist_r;
  logic                          ovld_r, olast_r, sk_vld_r, sk_last_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pmid_pkg::DIM_RESET;
      height_r <= pmid_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmid_pkg::CFG_DOMAIN_WIDTH:  width_r  <= cfg_data;
        pmid_pkg::CFG_DOMAIN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cap = 4 * width * height, registered product
  always_ff @(posedge clk) begin
    area_r <= width_r * height_r;
  end

  assign cap = {area_r, 2'b00};

  // Pipeline advances unless the skid stage holds an item
  assign en        = ~sk_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= {last_r[NSTG-2:0], in_tlast};
    end
  end

  // Per-axis least squared offset
  pmid_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk     (clk),
    .en      (en),
    .ref_c   (in_tdata[COORD_BITS-1:0]),
    .other_c (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .extent  (width_r),
    .sq      (sqx)
  );

  pmid_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk     (clk),
    .en      (en),
    .ref_c   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .other_c (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .extent  (height_r),
    .sq      (sqy)
  );

  // Sum of the two axes, limited by the cap
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (en) begin
      best_r <= (sum < (pmid_pkg::SQ_W+1)'(cap)) ? sum[pmid_pkg::BEST_W-1:0] : cap;
    end
  end

  // Square-root chain, most significant root bit first
  always_comb begin
    chain_head.valid = vld_r[NSTG-1];
    chain_head.last  = last_r[NSTG-1];
    chain_head.rad   = best_r;
    chain_head.rem   = '0;
    chain_head.root  = '0;
  end

  assign chain[0] = chain_head;

  for (genvar k = 0; k < pmid_pkg::ROOT_W; k++) begin : g_cell
    pmid_sqrt_cell #(.IDX(pmid_pkg::ROOT_W-1-k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (chain[k]),
      .s_out (chain[k+1])
    );
  end

  // Output register with one-item skid stage
  assign pop  = ovld_r & out_tready;
  assign push = en & chain[pmid_pkg::ROOT_W].valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r   <= 1'b0;
      sk_vld_r <= 1'b0;
    end else if (sk_vld_r) begin
      if (pop) begin
        dist_r   <= sk_dist_r;
        olast_r  <= sk_last_r;
        sk_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!ovld_r || pop) begin
        dist_r  <= chain[pmid_pkg::ROOT_W].root;
        olast_r <= chain[pmid_pkg::ROOT_W].last;
        ovld_r  <= 1'b1;
      end else begin
        sk_dist_r <= chain[pmid_pkg::ROOT_W].root;
        sk_last_r <= chain[pmid_pkg::ROOT_W].last;
        sk_vld_r  <= 1'b1;
      end
    end else if (pop) begin
      ovld_r <= 1'b0;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = pmid_pkg::OUT_TDATA_W'(dist_r);

endmodule

// ===== rtl/pmid_axis.sv =====
// ---------------------------------------------------------------------------
// pmid_axis
// One axis of the minimum-image search: forms the offset to the other point
// for the three periodic shifts, keeps the least magnitude and squares it.
// Four register stages.
// ---------------------------------------------------------------------------
module pmid_axis #(
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [COORD_BITS-1:0]           ref_c,
  input  logic [COORD_BITS-1:0]           other_c,
  input  logic [pmid_pkg::DIM_W-1:0]      extent,
  output logic [pmid_pkg::SQ_W-1:0]       sq
);

  localparam int DW = ((COORD_BITS > pmid_pkg::DIM_W) ? COORD_BITS : pmid_pkg::DIM_W) + 2;

  logic signed [DW-1:0] p_ext, q_ext, l_ext;
  logic signed [DW-1:0] d0_r, dm_r, dp_r;
  logic [pmid_pkg::MAG_W-1:0] m0_r, mm_r, mp_r;
  logic [pmid_pkg::MAG_W-1:0] min_r, min_a;
  logic [pmid_pkg::SQ_W-1:0]  sq_r;

  // Absolute value, clamped to where the square already exceeds any cap
  function automatic logic [pmid_pkg::MAG_W-1:0] mag_clamp(input logic signed [DW-1:0] v);
    logic [DW-1:0] mag;
    mag = v[DW-1] ? DW'(-v) : DW'(v);
    if (|mag[DW-1:pmid_pkg::MAG_W-1]) begin
      mag_clamp = pmid_pkg::MAG_SAT;
    end else begin
      mag_clamp = {1'b0, mag[pmid_pkg::MAG_W-2:0]};
    end
  endfunction

  assign p_ext = $signed(DW'(ref_c));
  assign q_ext = $signed(DW'(other_c));
  assign l_ext = $signed(DW'(extent));

  // Stage 1: offsets for shifts -1, 0, +1
  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= p_ext - q_ext;
      dm_r <= p_ext - q_ext - l_ext;
      dp_r <= p_ext - q_ext + l_ext;
    end
  end

  // Stage 2: clamped magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= mag_clamp(d0_r);
      mm_r <= mag_clamp(dm_r);
      mp_r <= mag_clamp(dp_r);
    end
  end

  // Stage 3: least of the three
  always_comb begin
    min_a = (mm_r < m0_r) ? mm_r : m0_r;
    if (mp_r < min_a) begin
      min_a = mp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      min_r <= min_a;
    end
  end

  // Stage 4: square
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= min_r * min_r;
    end
  end

  assign sq = sq_r;

endmodule

// ===== rtl/pmid_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// pmid_sqrt_cell
// One cell of the restoring square-root chain: brings down two radicand bits,
// tries the next root bit and passes the item on to its neighbor.
// ---------------------------------------------------------------------------
module pmid_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pmid_pkg::sqrt_stage_t s_in,
  output pmid_pkg::sqrt_stage_t s_out
);

  pmid_pkg::sqrt_stage_t s_r, s_nxt;
  logic [pmid_pkg::REM_W-1:0] rem_sh, trial;

  // Trial subtract of (4*root + 1)
  always_comb begin
    rem_sh = {s_in.rem[pmid_pkg::REM_W-3:0], s_in.rad[2*IDX+1 -: 2]};
    trial  = {1'b0, s_in.root, 2'b01};
    s_nxt  = s_in;
    if (rem_sh >= trial) begin
      s_nxt.rem  = rem_sh - trial;
      s_nxt.root = {s_in.root[pmid_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      s_nxt.rem  = rem_sh;
      s_nxt.root = {s_in.root[pmid_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule
